@@ design/knps_pkg.sv @@
// ----------------------------------------------------------------------------
// knps_pkg
// Shared types and constants of the k-nearest point selector: field widths,
// configuration register codes, the point store record and the state codes.
// ----------------------------------------------------------------------------
package knps_pkg;

  // payload field widths
  localparam int ID_W       = 16;
  localparam int COORD_W    = 24;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int SQ_W       = 2 * COORD_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int DIST_OUT_W = 52;

  // selection count
  localparam int SEL_W      = 7;
  localparam int MAX_SELECT = 64;

  // default store depth
  localparam int MAX_POINTS_DEF = 64;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = COORD_W;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_TARGETS = 2'd0,
    CFG_ORIGIN_X    = 2'd1,
    CFG_ORIGIN_Y    = 2'd2,
    CFG_ORIGIN_Z    = 2'd3
  } cfg_reg_t;

  // one entry of the point store
  typedef struct packed {
    logic        [ID_W-1:0]    id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_rec_t;

  // control sequencer
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_START,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

endpackage

@@ design/knps_in_if.sv @@
// ----------------------------------------------------------------------------
// knps_in_if
// Point input channel: valid/ready handshake with one candidate point.
// ----------------------------------------------------------------------------
interface knps_in_if;
  import knps_pkg::*;

  logic                      valid;
  logic                      ready;
  logic        [ID_W-1:0]    point_id;
  logic signed [COORD_W-1:0] pos_x;
  logic signed [COORD_W-1:0] pos_y;
  logic signed [COORD_W-1:0] pos_z;
  logic                      last_point;

  modport source (
    output valid, point_id, pos_x, pos_y, pos_z, last_point,
    input  ready
  );

  modport sink (
    input  valid, point_id, pos_x, pos_y, pos_z, last_point,
    output ready
  );
endinterface

@@ design/knps_out_if.sv @@
// ----------------------------------------------------------------------------
// knps_out_if
// Result channel: valid/ready handshake with one selected point.
// ----------------------------------------------------------------------------
interface knps_out_if;
  import knps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ID_W-1:0]       chosen_id;
  logic [DIST_OUT_W-1:0] dist_sq;
  logic                  overflow;
  logic                  last_result;

  modport source (
    output valid, chosen_id, dist_sq, overflow, last_result,
    input  ready
  );

  modport sink (
    input  valid, chosen_id, dist_sq, overflow, last_result,
    output ready
  );
endinterface

@@ design/knps_cfg_if.sv @@
// ----------------------------------------------------------------------------
// knps_cfg_if
// Configuration write channel: valid/ready handshake, register index and data.
// ----------------------------------------------------------------------------
interface knps_cfg_if;
  import knps_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (
    output valid, index, data,
    input  ready
  );

  modport sink (
    input  valid, index, data,
    output ready
  );
endinterface

@@ design/k_nearest_point_selector.sv @@
// ----------------------------------------------------------------------------
// k_nearest_point_selector
// Loads a set of 3-D points into a store and emits the K points nearest to
// a configured origin in increasing squared distance, or the whole set in
// input order when it holds no more than K points.
//
//   channel  dir  handshake          payload
//   in_ch    in   valid/ready        point_id, pos_x/y/z, last_point
//   out_ch   out  valid/ready        chosen_id, dist_sq, overflow, last_result
//   cfg_ch   in   valid/ready (rdy=1) index, data
//
// Loading takes one point per cycle. After the last point, each selection
// round reads the store once, one slot per cycle through a four-stage
// distance pipeline; in input-order mode a round reads only its own slot.
// The point store has a single read port. Input is held off from the last
// point until the final result sits in the output register. A stalled
// output holds the next round at its emit step. Reset is synchronous; no
// clearing pass.
// ----------------------------------------------------------------------------
module k_nearest_point_selector #(
  parameter int MAX_POINTS = knps_pkg::MAX_POINTS_DEF
) (
  input logic       clk,
  input logic       rst_n,
  knps_in_if.sink   in_ch,
  knps_out_if.source out_ch,
  knps_cfg_if.sink  cfg_ch
);
  import knps_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = (CW > SEL_W) ? CW : SEL_W;

  // configuration registers
  logic        [SEL_W-1:0]   max_tgt_r;
  logic signed [COORD_W-1:0] org_x_r, org_y_r, org_z_r;

  // control state
  state_t            state_r, state_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              ovf_r, ovf_nxt;
  logic              mode_all_r, mode_all_nxt;
  logic [SEL_W-1:0]  rounds_r, rounds_nxt;
  logic [SEL_W-1:0]  round_r, round_nxt;
  logic [AW-1:0]     scan_addr_r, scan_addr_nxt;
  logic [AW-1:0]     scan_hi_r, scan_hi_nxt;
  logic              round_start;

  // memories
  point_rec_t        pt_mem [MAX_POINTS];
  logic              tk_mem [MAX_POINTS];
  logic              pt_we;
  logic [AW-1:0]     pt_waddr;
  point_rec_t        pt_wdata;
  logic              tk_we;
  logic [AW-1:0]     tk_waddr;
  logic              tk_wdata;
  logic              rd_en;
  point_rec_t        mem_q;
  logic              tk_q;

  // distance pipeline
  logic                      rd_vld_r;
  logic [AW-1:0]             rd_slot_r;
  logic                      s1_vld_r, s1_skip_r;
  logic [AW-1:0]             s1_slot_r;
  logic [ID_W-1:0]           s1_id_r;
  logic signed [DIFF_W-1:0]  s1_dx_r, s1_dy_r, s1_dz_r;
  logic signed [2*DIFF_W-1:0] sq_x, sq_y, sq_z;
  logic                      s2_vld_r, s2_skip_r;
  logic [AW-1:0]             s2_slot_r;
  logic [ID_W-1:0]           s2_id_r;
  logic [SQ_W-1:0]           s2_x_r, s2_y_r, s2_z_r;
  logic                      s3_vld_r, s3_skip_r;
  logic [AW-1:0]             s3_slot_r;
  logic [ID_W-1:0]           s3_id_r;
  logic [DIST_W-1:0]         s3_sum_r;

  // running minimum
  logic              best_found_r;
  logic [DIST_W-1:0] best_dist_r;
  logic [AW-1:0]     best_slot_r;
  logic [ID_W-1:0]   best_id_r;

  // output register
  logic                  out_valid_r;
  logic [ID_W-1:0]       out_id_r;
  logic [DIST_OUT_W-1:0] out_dist_r;
  logic                  out_ovf_r;
  logic                  out_last_r;
  logic                  out_load;

  // helpers
  logic              in_accept;
  logic              store_room;
  logic [SEL_W-1:0]  k_eff;
  logic              fits_all;
  logic [SEL_W-1:0]  round_inc;
  logic              last_round;
  logic              pipe_busy;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_LOAD);
  assign in_accept    = in_ch.valid && in_ch.ready;
  assign store_room   = (count_r < CW'(MAX_POINTS));
  assign k_eff        = (max_tgt_r > SEL_W'(MAX_SELECT)) ? SEL_W'(MAX_SELECT) : max_tgt_r;
  assign fits_all     = (NW'(count_r) <= NW'(k_eff));
  assign round_inc    = round_r + SEL_W'(1);
  assign last_round   = (round_inc == rounds_r);
  assign pipe_busy    = rd_vld_r || s1_vld_r || s2_vld_r || s3_vld_r;
  assign out_load     = (state_r == ST_EMIT) && (!out_valid_r || out_ch.ready);
  assign rd_en        = (state_r == ST_SCAN);

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_tgt_r <= SEL_W'(1);
      org_x_r   <= '0;
      org_y_r   <= '0;
      org_z_r   <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        CFG_MAX_TARGETS: max_tgt_r <= cfg_ch.data[SEL_W-1:0];
        CFG_ORIGIN_X:    org_x_r   <= cfg_ch.data;
        CFG_ORIGIN_Y:    org_y_r   <= cfg_ch.data;
        CFG_ORIGIN_Z:    org_z_r   <= cfg_ch.data;
        default:         ;
      endcase
    end
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      mode_all_r  <= 1'b0;
      rounds_r    <= '0;
      round_r     <= '0;
      scan_addr_r <= '0;
      scan_hi_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      mode_all_r  <= mode_all_nxt;
      rounds_r    <= rounds_nxt;
      round_r     <= round_nxt;
      scan_addr_r <= scan_addr_nxt;
      scan_hi_r   <= scan_hi_nxt;
    end
  end

  // next state, store writes and round setup
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    mode_all_nxt  = mode_all_r;
    rounds_nxt    = rounds_r;
    round_nxt     = round_r;
    scan_addr_nxt = scan_addr_r;
    scan_hi_nxt   = scan_hi_r;
    round_start   = 1'b0;
    pt_we         = 1'b0;
    pt_waddr      = AW'(count_r);
    pt_wdata      = '{id: in_ch.point_id, x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z};
    tk_we         = 1'b0;
    tk_waddr      = AW'(count_r);
    tk_wdata      = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_accept) begin
          if (store_room) begin
            pt_we     = 1'b1;
            tk_we     = 1'b1;
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_ch.last_point) begin
            state_nxt = ST_START;
          end
        end
      end

      ST_START: begin
        mode_all_nxt  = fits_all;
        rounds_nxt    = fits_all ? SEL_W'(count_r) : k_eff;
        round_nxt     = '0;
        scan_addr_nxt = '0;
        scan_hi_nxt   = fits_all ? AW'(0) : AW'(count_r - CW'(1));
        if ((fits_all ? SEL_W'(count_r) : k_eff) == '0) begin
          // nothing to select: drop the set
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          round_start = 1'b1;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (scan_addr_r == scan_hi_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          scan_addr_nxt = scan_addr_r + AW'(1);
        end
      end

      ST_DRAIN: begin
        if (!pipe_busy) begin
          state_nxt = ST_EMIT;
        end
      end

      ST_EMIT: begin
        if (out_load) begin
          // mark the winner so later rounds skip it
          tk_we    = 1'b1;
          tk_waddr = best_slot_r;
          tk_wdata = 1'b1;
          if (last_round) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = ST_LOAD;
          end else begin
            round_nxt     = round_inc;
            scan_addr_nxt = mode_all_r ? AW'(round_inc) : AW'(0);
            scan_hi_nxt   = mode_all_r ? AW'(round_inc) : scan_hi_r;
            round_start   = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end

      default: state_nxt = ST_LOAD;
    endcase
  end

  // point store and taken flags, registered reads
  always_ff @(posedge clk) begin
    if (pt_we) begin
      pt_mem[pt_waddr] <= pt_wdata;
    end
    if (tk_we) begin
      tk_mem[tk_waddr] <= tk_wdata;
    end
    if (rd_en) begin
      mem_q <= pt_mem[scan_addr_r];
      tk_q  <= tk_mem[scan_addr_r];
    end
  end

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= rd_en;
      s1_vld_r <= rd_vld_r;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  // squares of the differences
  always_comb begin
    sq_x = s1_dx_r * s1_dx_r;
    sq_y = s1_dy_r * s1_dy_r;
    sq_z = s1_dz_r * s1_dz_r;
  end

  // distance pipeline payload
  always_ff @(posedge clk) begin
    rd_slot_r <= scan_addr_r;

    // stage 1: differences to the origin
    s1_skip_r <= tk_q;
    s1_slot_r <= rd_slot_r;
    s1_id_r   <= mem_q.id;
    s1_dx_r   <= DIFF_W'(mem_q.x) - DIFF_W'(org_x_r);
    s1_dy_r   <= DIFF_W'(mem_q.y) - DIFF_W'(org_y_r);
    s1_dz_r   <= DIFF_W'(mem_q.z) - DIFF_W'(org_z_r);

    // stage 2: squares
    s2_skip_r <= s1_skip_r;
    s2_slot_r <= s1_slot_r;
    s2_id_r   <= s1_id_r;
    s2_x_r    <= sq_x[SQ_W-1:0];
    s2_y_r    <= sq_y[SQ_W-1:0];
    s2_z_r    <= sq_z[SQ_W-1:0];

    // stage 3: sum
    s3_skip_r <= s2_skip_r;
    s3_slot_r <= s2_slot_r;
    s3_id_r   <= s2_id_r;
    s3_sum_r  <= DIST_W'(s2_x_r) + DIST_W'(s2_y_r) + DIST_W'(s2_z_r);
  end

  // running minimum, earliest slot wins ties
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_found_r <= 1'b0;
    end else if (round_start) begin
      best_found_r <= 1'b0;
    end else if (s3_vld_r && !s3_skip_r && (!best_found_r || s3_sum_r < best_dist_r)) begin
      best_found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_vld_r && !s3_skip_r && (!best_found_r || s3_sum_r < best_dist_r)) begin
      best_dist_r <= s3_sum_r;
      best_slot_r <= s3_slot_r;
      best_id_r   <= s3_id_r;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_id_r   <= best_id_r;
      out_dist_r <= DIST_OUT_W'(best_dist_r);
      out_ovf_r  <= ovf_r;
      out_last_r <= last_round;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.chosen_id   = out_id_r;
  assign out_ch.dist_sq     = out_dist_r;
  assign out_ch.overflow    = out_ovf_r;
  assign out_ch.last_result = out_last_r;

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the k-nearest point selector. Point sets are queued
// by a sequencing process and offered by a clocked driver. A local predictor
// replays every accepted point into its own store and queues the selection
// that the set produces. A clocked monitor checks each result transaction
// against the oldest prediction. Both handshake sides idle at random, and
// one long output stall forces the block to hold off its input.
// ----------------------------------------------------------------------------
module tb_top;
  import knps_pkg::*;

  localparam int STORE_DEPTH   = MAX_POINTS_DEF;
  localparam int RAND_ITEMS    = 150;
  localparam int SETTLE_CYCLES = 150;
  localparam int HOLD_CYCLES   = 800;
  localparam int CALM_FROM     = 1500;
  localparam int CALM_TO       = 4000;

  // one candidate point as offered on the input channel
  typedef struct packed {
    logic        [ID_W-1:0]    id;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
    logic                      last;
  } cand_t;

  // one predicted selection
  typedef struct packed {
    logic [ID_W-1:0]       id;
    logic [DIST_OUT_W-1:0] dsq;
    logic                  ovf;
    logic                  last;
  } pick_t;

  logic clk = 1'b0;
  logic rst_n;

  knps_in_if  in_ch();
  knps_out_if out_ch();
  knps_cfg_if cfg_ch();

  k_nearest_point_selector uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // queues between sequencer, driver, predictor and monitor
  cand_t points_due[$];
  pick_t picks_due[$];
  int    pts_sent  = 0;
  int    pts_taken = 0;
  int    err_count = 0;
  int    cyc       = 0;

  // predictor copy of configuration and store
  logic        [SEL_W-1:0]   k_reg;
  logic signed [COORD_W-1:0] org_x;
  logic signed [COORD_W-1:0] org_y;
  logic signed [COORD_W-1:0] org_z;
  point_rec_t                store [STORE_DEPTH];
  logic [STORE_DEPTH-1:0]    taken;
  int                        stored_n;
  bit                        dropped;

  cfg_reg_t axis_reg [3] = '{CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z};

  // output stall control
  bit hold_req  = 1'b0;
  bit hold_used;
  int hold_cnt;

  cand_t nxt;
  pick_t want;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) cyc <= cyc + 1;

  task automatic flag_error(input string what);
    $display("ERROR @%0t: %s", $time, what);
    err_count++;
  endtask

  // random idle decision, off during the calm window
  function automatic bit gap_now();
    if (cyc >= CALM_FROM && cyc < CALM_TO) return 1'b0;
    return $urandom_range(99) < 14;
  endfunction

  // squared euclidean distance from the configured origin, exact
  function automatic logic [DIST_OUT_W-1:0] dist_to_origin(input point_rec_t p);
    longint dx, dy, dz;
    dx = longint'(p.x) - longint'(org_x);
    dy = longint'(p.y) - longint'(org_y);
    dz = longint'(p.z) - longint'(org_z);
    return DIST_OUT_W'(dx * dx + dy * dy + dz * dz);
  endfunction

  task automatic push_pick(input int slot, input bit last);
    pick_t p;
    p.id   = store[slot].id;
    p.dsq  = dist_to_origin(store[slot]);
    p.ovf  = dropped;
    p.last = last;
    picks_due.push_back(p);
  endtask

  // store one point; on the closing point, queue the selection and clear
  task automatic absorb_point(input cand_t c);
    int k, n, best;
    bit found;
    logic [DIST_OUT_W-1:0] d, best_d;
    if (stored_n < STORE_DEPTH) begin
      store[stored_n] = '{c.id, c.x, c.y, c.z};
      taken[stored_n] = 1'b0;
      stored_n++;
    end else begin
      dropped = 1'b1;
    end
    if (c.last) begin
      k = (int'(k_reg) > MAX_SELECT) ? MAX_SELECT : int'(k_reg);
      n = stored_n;
      if (n <= k) begin
        // small set: everything in load order
        for (int i = 0; i < n; i++) push_pick(i, i == n - 1);
      end else begin
        // repeated minimum, earliest slot wins a tie
        for (int r = 0; r < k; r++) begin
          found  = 1'b0;
          best   = 0;
          best_d = '0;
          for (int i = 0; i < n; i++) begin
            if (!taken[i]) begin
              d = dist_to_origin(store[i]);
              if (!found || d < best_d) begin
                found  = 1'b1;
                best   = i;
                best_d = d;
              end
            end
          end
          taken[best] = 1'b1;
          push_pick(best, r == k - 1);
        end
      end
      taken    = '0;
      stored_n = 0;
      dropped  = 1'b0;
    end
  endtask

  // one register write transaction, mirrored into the predictor
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      CFG_MAX_TARGETS: k_reg = val[SEL_W-1:0];
      CFG_ORIGIN_X:    org_x = val;
      CFG_ORIGIN_Y:    org_y = val;
      CFG_ORIGIN_Z:    org_z = val;
      default: ;
    endcase
  endtask

  task automatic queue_point(input logic [ID_W-1:0] id, input logic signed [COORD_W-1:0] x,
                             input logic signed [COORD_W-1:0] y,
                             input logic signed [COORD_W-1:0] z, input bit last);
    cand_t c;
    c = '{id, x, y, z, last};
    points_due.push_back(c);
    pts_sent++;
  endtask

  // coordinate: full range, near the origin, or on a coarse grid for ties
  function automatic logic signed [COORD_W-1:0] pick_coord(
      input logic signed [COORD_W-1:0] org, input int mode);
    case (mode)
      0:       return COORD_W'($urandom);
      1:       return org + COORD_W'(int'($urandom_range(0, 200)) - 100);
      default: return org + COORD_W'((int'($urandom_range(0, 4)) - 2) * 16);
    endcase
  endfunction

  // random set of n points with distinct ids
  task automatic queue_rand_set(input int n);
    int mode;
    logic [ID_W-1:0] base, stride, id;
    logic signed [COORD_W-1:0] x, y, z;
    mode   = $urandom_range(0, 2);
    base   = ID_W'($urandom);
    stride = ID_W'($urandom) | 16'd1;
    x = '0;
    y = '0;
    z = '0;
    for (int j = 0; j < n; j++) begin
      id = base + ID_W'(j) * stride;
      // outside full-range mode, some points repeat the previous position
      if (j == 0 || mode == 0 || $urandom_range(3) != 0) begin
        x = pick_coord(org_x, mode);
        y = pick_coord(org_y, mode);
        z = pick_coord(org_z, mode);
      end
      queue_point(id, x, y, z, j == n - 1);
    end
  endtask

  task automatic wait_drained();
    while (pts_taken != pts_sent || picks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (points_due.size() != 0 && !gap_now()) begin
        nxt = points_due.pop_front();
        in_ch.valid      <= 1'b1;
        in_ch.point_id   <= nxt.id;
        in_ch.pos_x      <= nxt.x;
        in_ch.pos_y      <= nxt.y;
        in_ch.pos_z      <= nxt.z;
        in_ch.last_point <= nxt.last;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // predictor fed by accepted input transactions
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      absorb_point('{in_ch.point_id, in_ch.pos_x, in_ch.pos_y, in_ch.pos_z,
                     in_ch.last_point});
      pts_taken++;
    end
  end

  // long output stall, counted down once when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt  <= 0;
      hold_used <= 1'b0;
    end else if (hold_req && !hold_used) begin
      hold_cnt  <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // result receiver
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= (hold_cnt == 0) && !gap_now();
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (picks_due.size() == 0) begin
        flag_error($sformatf("result id %h arrived with nothing due", out_ch.chosen_id));
      end else begin
        want = picks_due.pop_front();
        if (out_ch.chosen_id !== want.id)
          flag_error($sformatf("chosen_id %h, want %h", out_ch.chosen_id, want.id));
        if (out_ch.dist_sq !== want.dsq)
          flag_error($sformatf("dist_sq %h, want %h (id %h)", out_ch.dist_sq, want.dsq,
                               want.id));
        if (out_ch.overflow !== want.ovf)
          flag_error($sformatf("overflow %b, want %b (id %h)", out_ch.overflow, want.ovf,
                               want.id));
        if (out_ch.last_result !== want.last)
          flag_error($sformatf("last_result %b, want %b (id %h)", out_ch.last_result,
                               want.last, want.id));
      end
    end
  end

  // sequencer: directed sets, then random phases
  initial begin
    int n_rand, phase, budget, sz, omode;
    logic [SEL_W-1:0] kv;
    logic [CFG_DATA_W-1:0] ov;
    n_rand = 0;
    phase  = 0;

    // defined levels from time zero, predictor at reset state
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.point_id   = '0;
    in_ch.pos_x      = '0;
    in_ch.pos_y      = '0;
    in_ch.pos_z      = '0;
    in_ch.last_point = 1'b0;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_MAX_TARGETS;
    cfg_ch.data      = '0;
    k_reg    = 7'd1;
    org_x    = '0;
    org_y    = '0;
    org_z    = '0;
    taken    = '0;
    stored_n = 0;
    dropped  = 1'b0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: single point set, then a tie for the one nearest
    queue_point(16'h0000, 24'sd0, 24'sd0, 24'sd0, 1'b1);
    queue_point(16'hFFFF, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
    queue_point(16'h0001, 24'sd1, -24'sd1, 24'sd1, 1'b0);
    queue_point(16'h0002, 24'sd1, 24'sd1, -24'sd1, 1'b1);
    wait_drained();

    // extreme origin, set exactly as large as K
    write_reg(CFG_MAX_TARGETS, 24'd3);
    write_reg(CFG_ORIGIN_X, 24'h800000);
    write_reg(CFG_ORIGIN_Y, 24'h7FFFFF);
    write_reg(CFG_ORIGIN_Z, 24'h800000);
    queue_point(16'h0010, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 1'b0);
    queue_point(16'h0011, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b0);
    queue_point(16'h0012, 24'sd0, 24'sd0, 24'sd0, 1'b1);
    wait_drained();

    // selection with equal distances and a repeated position
    write_reg(CFG_MAX_TARGETS, 24'd2);
    write_reg(CFG_ORIGIN_X, 24'sd100);
    write_reg(CFG_ORIGIN_Y, -24'sd200);
    write_reg(CFG_ORIGIN_Z, 24'sd300);
    queue_point(16'h0020, 24'sd110, -24'sd200, 24'sd300, 1'b0);
    queue_point(16'h0021, 24'sd100, -24'sd190, 24'sd300, 1'b0);
    queue_point(16'h0022, 24'sd100, -24'sd200, 24'sd300, 1'b0);
    queue_point(16'h0023, 24'sd110, -24'sd200, 24'sd300, 1'b0);
    queue_point(16'h0024, 24'h800000, 24'h7FFFFF, 24'h800000, 1'b1);
    wait_drained();

    // zero targets, upper data bits set: sets clear without results
    write_reg(CFG_MAX_TARGETS, 24'hFFFF80);
    queue_point(16'h0030, 24'sd5, 24'sd6, 24'sd7, 1'b0);
    queue_point(16'h0031, -24'sd5, -24'sd6, -24'sd7, 1'b1);
    queue_point(16'h0032, 24'sd0, 24'sd0, 24'sd0, 1'b1);
    wait_drained();

    // targets above the cap act as the cap
    write_reg(CFG_MAX_TARGETS, 24'h00007F);
    write_reg(CFG_ORIGIN_X, 24'h7FFFFF);
    write_reg(CFG_ORIGIN_Y, -24'sd1);
    write_reg(CFG_ORIGIN_Z, 24'sd0);
    queue_point(16'h0040, 24'h800000, 24'h800000, 24'h800000, 1'b0);
    queue_point(16'h0041, 24'h7FFFFF, -24'sd1, 24'sd0, 1'b0);
    queue_point(16'h0042, 24'sd0, 24'h7FFFFF, 24'h800000, 1'b0);
    queue_point(16'h0043, -24'sd1, 24'sd1, -24'sd1, 1'b1);
    wait_drained();

    // random phases, each with fresh settings
    while (n_rand < RAND_ITEMS) begin
      case ($urandom_range(9))
        0:       kv = 7'd0;
        1:       kv = 7'd64;
        2:       kv = 7'd127;
        3:       kv = SEL_W'($urandom_range(65, 127));
        default: kv = SEL_W'($urandom_range(1, 8));
      endcase
      if (phase == 2) kv = SEL_W'($urandom_range(2, 20));
      write_reg(CFG_MAX_TARGETS, {($urandom_range(1) != 0) ? 17'($urandom) : 17'd0, kv});
      for (int a = 0; a < 3; a++) begin
        omode = $urandom_range(9);
        if (omode == 0)      ov = '0;
        else if (omode == 1) ov = ($urandom_range(1) != 0) ? 24'h7FFFFF : 24'h800000;
        else if (omode < 5)  ov = CFG_DATA_W'(int'($urandom_range(0, 4000)) - 2000);
        else                 ov = CFG_DATA_W'($urandom);
        write_reg(axis_reg[a], ov);
      end

      // overflowing set under a long output stall, later sets back up on input
      if (phase == 2) begin
        hold_req <= 1'b1;
        queue_rand_set(STORE_DEPTH + 2);
        n_rand += STORE_DEPTH + 2;
      end

      budget = $urandom_range(12, 24);
      while (budget > 0) begin
        case ($urandom_range(9))
          7, 8:    sz = $urandom_range(9, 16);
          9:       sz = 1;
          default: sz = $urandom_range(1, 8);
        endcase
        queue_rand_set(sz);
        budget -= sz;
        n_rand += sz;
      end
      wait_drained();
      phase++;
    end

    if (picks_due.size() != 0) flag_error("results still due at end of run");
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
